[rtl/core/cts_pkg.sv]
// ============================================================================
// cts_pkg
// Shared constants and types of the cyclic time sensor: parameter defaults,
// register indexes, controller states and the controller/datapath bundles.
// ============================================================================
`default_nettype none

package cts_pkg;

    localparam int TIME_BITS_DEF     = 48;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int INTERVAL_BITS     = 32;
    localparam int CFG_INDEX_BITS    = 2;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CYCLE_INTERVAL = 2'd0,
        REG_START_TIME     = 2'd1,
        REG_STOP_TIME      = 2'd2,
        REG_LOOP_ENABLE    = 2'd3
    } cts_reg_idx_t;

    // Controller states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b0_0000_0001,
        ST_ACT    = 9'b0_0000_0010,
        ST_STOP   = 9'b0_0000_0100,
        ST_ENDCHK = 9'b0_0000_1000,
        ST_DIFF   = 9'b0_0001_0000,
        ST_MOD    = 9'b0_0010_0000,
        ST_FIX    = 9'b0_0100_0000,
        ST_DIV    = 9'b0_1000_0000,
        ST_DONE   = 9'b1_0000_0000
    } cts_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic act;
        logic stop;
        logic endchk;
        logic diff;
        logic mod_step;
        logic fix;
        logic div_step;
        logic load_out;
    } cts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } cts_stat_t;

endpackage

`default_nettype wire

[rtl/core/cyclic_time_sensor.sv]
// ============================================================================
// cyclic_time_sensor
// Cyclic time sensor on integer ticks: tracks activation, stop and cycle
// wrap from a stream of time items and reports the position in the cycle.
// ============================================================================
//
//  Channel   Direction  Beat contents
//  --------  ---------  ----------------------------------------------------
//  s_axis    in         global_time
//  m_axis    out        status, cycle start and Q0.FRACTION_BITS fraction
//  cfg       in         register index and write data
//
//  An item runs through the checks, the serial modulo over the time
//  distance and the serial fraction divide, one bit a cycle each, before
//  the next item is accepted.
//  The result sits in an output register, so a new item is taken while it
//  waits; if it still waits when the next item is done, the sequencer holds
//  in its last state. Reset is synchronous and active low; cfg is always ready.
//
`default_nettype none

module cyclic_time_sensor #(
    parameter int TIME_BITS     = cts_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = cts_pkg::FRACTION_BITS_DEF,
    parameter int IN_W          = ((TIME_BITS + 7) / 8) * 8,
    parameter int OUT_W         = ((TIME_BITS + FRACTION_BITS + 3 + 7) / 8) * 8,
    parameter int CFG_W         = (TIME_BITS > cts_pkg::INTERVAL_BITS) ?
                                  TIME_BITS : cts_pkg::INTERVAL_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: global_time.
    input  wire logic [IN_W-1:0]                   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // Fields from bit 0: is_active, active_changed, cycle_start,
    // cycle_start_changed, fraction.
    output logic [OUT_W-1:0]                       m_axis_tdata,
    // Fields from bit 0: fraction_valid.
    output logic [0:0]                             m_axis_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]                  cfg_data
);
    import cts_pkg::*;

    cts_cmd_t  cmd;
    cts_stat_t stat;

    logic                     o_act;
    logic                     o_chg;
    logic [TIME_BITS-1:0]     o_cs;
    logic                     o_csc;
    logic [FRACTION_BITS-1:0] o_frac;
    logic                     o_fv;

    // Configuration writes are never stalled.
    assign cfg_ready = 1'b1;

    cts_ctrl #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cts_datapath #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .CFG_W         (CFG_W)
    ) u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .stat                    (stat),
        .in_time                 (s_axis_tdata[TIME_BITS-1:0]),
        .cfg_wr                  (cfg_valid),
        .cfg_idx                 (cfg_index),
        .cfg_wdata               (cfg_data),
        .out_valid               (m_axis_tvalid),
        .out_ready               (m_axis_tready),
        .out_is_active           (o_act),
        .out_active_changed      (o_chg),
        .out_cycle_start         (o_cs),
        .out_cycle_start_changed (o_csc),
        .out_fraction            (o_frac),
        .out_fraction_valid      (o_fv)
    );

    // Pack the result beat; the size cast fills the top with zeros.
    assign m_axis_tdata = OUT_W'({o_frac, o_csc, o_cs, o_chg, o_act});
    assign m_axis_tuser = o_fv;

endmodule

`default_nettype wire

[rtl/core/cts_ctrl.sv]
// ============================================================================
// cts_ctrl
// Sequencer of the cyclic time sensor: steps one time item through the
// activation, stop and cycle-end checks, the serial modulo and the serial
// fraction divide, and hands the result to the output register.
// ============================================================================
`default_nettype none

module cts_ctrl #(
    parameter int TIME_BITS     = cts_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = cts_pkg::FRACTION_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cts_pkg::cts_stat_t stat,
    output cts_pkg::cts_cmd_t      cmd
);
    import cts_pkg::*;

    localparam int STEPS_MAX = (TIME_BITS > FRACTION_BITS) ? TIME_BITS : FRACTION_BITS;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);

    cts_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid) begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT: begin
                cmd.act    = 1'b1;
                state_next = ST_STOP;
            end
            ST_STOP: begin
                cmd.stop   = 1'b1;
                state_next = ST_ENDCHK;
            end
            ST_ENDCHK: begin
                cmd.endchk = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                cnt_next   = CNT_W'(TIME_BITS - 1);
                state_next = ST_MOD;
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                cnt_next   = CNT_W'(FRACTION_BITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cts_datapath.sv]
// ============================================================================
// cts_datapath
// Registers, sensor state, cycle arithmetic, a shared shift-subtract unit for
// the modulo and the fraction divide, and the output register.
// ============================================================================
`default_nettype none

module cts_datapath #(
    parameter int TIME_BITS     = cts_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = cts_pkg::FRACTION_BITS_DEF,
    parameter int CFG_W         = (TIME_BITS > cts_pkg::INTERVAL_BITS) ?
                                  TIME_BITS : cts_pkg::INTERVAL_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cts_pkg::cts_cmd_t                 cmd,
    output cts_pkg::cts_stat_t                     stat,
    input  wire logic [TIME_BITS-1:0]              in_time,
    input  wire logic                              cfg_wr,
    input  wire logic [cts_pkg::CFG_INDEX_BITS-1:0] cfg_idx,
    input  wire logic [CFG_W-1:0]                  cfg_wdata,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_is_active,
    output logic                                   out_active_changed,
    output logic [TIME_BITS-1:0]                   out_cycle_start,
    output logic                                   out_cycle_start_changed,
    output logic [FRACTION_BITS-1:0]               out_fraction,
    output logic                                   out_fraction_valid
);
    import cts_pkg::*;

    localparam int IW    = INTERVAL_BITS;
    localparam int SUM_W = ((TIME_BITS > IW) ? TIME_BITS : IW) + 1;
    localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = '1;

    // Configuration.
    logic [IW-1:0]        interval_reg;
    logic [TIME_BITS-1:0] stop_reg;
    logic                 loop_reg;
    // Sensor state.
    logic                 active_reg, active_next;
    logic [TIME_BITS-1:0] begin_reg, begin_next;
    logic [TIME_BITS-1:0] eff_reg, eff_next;
    // Per-item work registers.
    logic [TIME_BITS-1:0] t_reg;
    logic                 was_reg;
    logic                 newc_reg, newc_next;
    logic [TIME_BITS-1:0] end_reg;
    logic [TIME_BITS-1:0] d_reg, d_next;
    logic                 neg_reg;
    logic [IW-1:0]        rem_reg, rem_next;
    logic [FRACTION_BITS-1:0] quo_reg;
    logic                 ovalid_reg;

    logic [IW-1:0]    iv;
    logic [SUM_W-1:0] sum;
    logic [IW:0]      sh;
    logic [IW:0]      sh_sub;
    logic             ge;

    // A zero interval behaves as one tick.
    assign iv  = (interval_reg == '0) ? IW'(1) : interval_reg;
    assign sum = SUM_W'(begin_reg) + SUM_W'(iv);

    // Shared restoring step: the modulo shifts in the next bit of the
    // distance, the divide shifts in zeros and collects quotient bits.
    assign sh     = {rem_reg, cmd.mod_step ? d_reg[TIME_BITS-1] : 1'b0};
    assign sh_sub = sh - {1'b0, iv};
    assign ge     = (sh >= {1'b0, iv});

    always_comb begin
        active_next = active_reg;
        begin_next  = begin_reg;
        eff_next    = eff_reg;
        newc_next   = newc_reg;
        d_next      = d_reg;
        rem_next    = rem_reg;
        if (cmd.load_in) begin
            newc_next = 1'b0;
        end
        if (cmd.act && !active_reg && (eff_reg != TIME_ALL_ONES) && (t_reg >= eff_reg)) begin
            active_next = 1'b1;
            begin_next  = t_reg;
            newc_next   = 1'b1;
        end
        if (cmd.stop && (stop_reg > eff_reg) && (t_reg > stop_reg)) begin
            eff_next    = TIME_ALL_ONES;
            active_next = 1'b0;
        end
        if (cmd.endchk && active_reg && (t_reg > end_reg)) begin
            if (loop_reg) begin
                begin_next = sum[TIME_BITS-1:0];
                newc_next  = 1'b1;
            end else begin
                eff_next    = TIME_ALL_ONES;
                active_next = 1'b0;
            end
        end
        if (cmd.diff) begin
            d_next   = (t_reg >= eff_reg) ? (t_reg - eff_reg) : (eff_reg - t_reg);
            rem_next = '0;
        end
        if (cmd.mod_step) begin
            d_next   = {d_reg[TIME_BITS-2:0], 1'b0};
            rem_next = ge ? sh_sub[IW-1:0] : sh[IW-1:0];
        end
        if (cmd.fix && neg_reg && (rem_reg != '0)) begin
            rem_next = iv - rem_reg;
        end
        if (cmd.div_step) begin
            rem_next = ge ? sh_sub[IW-1:0] : sh[IW-1:0];
        end
        // Writing the start register reloads the effective start.
        if (cfg_wr && (cfg_idx == REG_START_TIME)) begin
            eff_next = cfg_wdata[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= IW'(1);
            stop_reg     <= '0;
            loop_reg     <= 1'b0;
            active_reg   <= 1'b0;
            begin_reg    <= '0;
            eff_reg      <= '0;
            newc_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            begin_reg  <= begin_next;
            eff_reg    <= eff_next;
            newc_reg   <= newc_next;
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_CYCLE_INTERVAL: interval_reg <= cfg_wdata[IW-1:0];
                    REG_STOP_TIME:      stop_reg     <= cfg_wdata[TIME_BITS-1:0];
                    REG_LOOP_ENABLE:    loop_reg     <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (cmd.load_out) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        d_reg   <= d_next;
        rem_reg <= rem_next;
        if (cmd.load_in) begin
            t_reg   <= in_time;
            was_reg <= active_reg;
        end
        // Cycle end saturates at all ones, so no time can pass it.
        if (cmd.stop) begin
            end_reg <= (sum > SUM_W'(TIME_ALL_ONES)) ? TIME_ALL_ONES : sum[TIME_BITS-1:0];
        end
        if (cmd.diff) begin
            neg_reg <= (t_reg < eff_reg);
        end
        if (cmd.div_step) begin
            quo_reg <= {quo_reg[FRACTION_BITS-2:0], ge};
        end
        if (cmd.load_out) begin
            out_is_active           <= active_reg;
            out_active_changed      <= (active_reg != was_reg);
            out_cycle_start         <= begin_reg;
            out_cycle_start_changed <= newc_reg;
            out_fraction            <= active_reg ? quo_reg : '0;
            out_fraction_valid      <= active_reg;
        end
    end

    assign out_valid     = ovalid_reg;
    assign stat.out_free = !ovalid_reg || out_ready;

endmodule

`default_nettype wire

[rtl/core/cts_checker.sv]
// ============================================================================
// cts_checker
// Port-level checks of the cyclic time sensor, bound to the top level.
// ============================================================================
`default_nettype none

module cts_checker #(
    parameter int TIME_BITS     = cts_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = cts_pkg::FRACTION_BITS_DEF,
    parameter int OUT_W         = ((TIME_BITS + FRACTION_BITS + 3 + 7) / 8) * 8
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [OUT_W-1:0]                  m_axis_tdata,
    input wire logic [0:0]                        m_axis_tuser
);
    localparam int FRAC_LSB = TIME_BITS + 3;

    logic                     act_bit;
    logic [FRACTION_BITS-1:0] frac_bits;

    assign act_bit   = m_axis_tdata[0];
    assign frac_bits = m_axis_tdata[FRAC_LSB +: FRACTION_BITS];

    // The fraction is flagged valid exactly when the sensor is active.
    a_fv_matches_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[0] == act_bit))
        else $error("fraction_valid differs from is_active");

    // An inactive result carries a zero fraction.
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !act_bit) |-> (frac_bits == '0))
        else $error("inactive result with nonzero fraction");

    // One item at a time: the input closes after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result beat changed");

endmodule

bind cyclic_time_sensor cts_checker #(
    .TIME_BITS     (TIME_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .OUT_W         (OUT_W)
) u_cts_checker (.*);

`default_nettype wire

[dv/tb_cyclic_time_sensor.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_cyclic_time_sensor
// Self-checking bench for the cyclic time sensor. A short table of register
// writes and time ticks covers the corner cases. Random runs of ticks follow,
// each run under a fresh register setting. Every result beat is compared field
// by field with a hand-written result or with a behavioral model of the sensor
// kept inside the bench. Both stream sides idle at random.
// ============================================================================

module tb_cyclic_time_sensor;
    import cts_pkg::*;

    localparam int TB    = TIME_BITS_DEF;
    localparam int FB    = FRACTION_BITS_DEF;
    localparam int IN_W  = ((TB + 7) / 8) * 8;
    localparam int OUT_W = ((TB + FB + 3 + 7) / 8) * 8;
    localparam int CFG_W = (TB > INTERVAL_BITS) ? TB : INTERVAL_BITS;

    // All ones on the time axis: the largest tick and the "indefinite" start.
    localparam logic [TB-1:0] TICK_MAX = '1;

    localparam int RANDOM_TICKS = 360;

    // One result beat, unpacked from tdata and tuser.
    typedef struct packed {
        logic          is_active;
        logic          active_changed;
        logic [TB-1:0] cycle_start;
        logic          cycle_started;
        logic [FB-1:0] fraction;
        logic          fraction_valid;
    } sensor_result_t;

    typedef enum {ROW_WRITE, ROW_TICK} row_kind_t;

    // One line of the directed table: either a register write or a tick. A
    // tick may carry a hand-written result; otherwise the model supplies it.
    typedef struct {
        row_kind_t      kind;
        cts_reg_idx_t   reg_id;
        logic [63:0]    value;
        bit             typed;
        sensor_result_t result;
    } script_row_t;

    // ------------------------------------------------------------------------
    // DUT connections. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    wire              s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    wire  [OUT_W-1:0] m_axis_tdata;
    wire  [0:0]       m_axis_tuser;
    logic             cfg_valid     = 1'b0;
    wire              cfg_ready;
    cts_reg_idx_t     cfg_index     = REG_CYCLE_INTERVAL;
    logic [CFG_W-1:0] cfg_data      = '0;

    cyclic_time_sensor DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Model of the sensor: registers and state as they stand after reset.
    // ------------------------------------------------------------------------
    logic [31:0]   interval_reg  = 32'd1;
    logic [TB-1:0] stop_reg      = '0;
    logic          loop_reg      = 1'b0;
    logic          sensor_active = 1'b0;
    logic [TB-1:0] cycle_begin   = '0;
    logic [TB-1:0] eff_start     = '0;

    sensor_result_t pending_results[$];
    script_row_t    directed_rows[$];

    int  error_count  = 0;
    int  results_seen = 0;
    bit  tx_steady    = 1'b0;
    bit  rx_steady    = 1'b0;
    int  rx_hold      = 0;

    // A zero interval behaves like an interval of one tick.
    function automatic logic [63:0] interval_ticks();
        return (interval_reg == 0) ? 64'd1 : 64'(interval_reg);
    endfunction

    // Position within the cycle as Q0.FB. The remainder is a floor modulo, so
    // a time below the effective start still lands in [0, interval).
    function automatic logic [FB-1:0] cycle_fraction(logic [TB-1:0] t);
        logic [63:0] iv;
        logic [63:0] r;
        iv = interval_ticks();
        if (t >= eff_start) begin
            r = 64'(t - eff_start) % iv;
        end else begin
            r = 64'(eff_start - t) % iv;
            if (r != 0) r = iv - r;
        end
        return FB'((r << FB) / iv);
    endfunction

    // Writing the start register also reloads the effective start, which is
    // how an indefinite start gets cleared again.
    function automatic void load_register(cts_reg_idx_t idx, logic [63:0] v);
        case (idx)
            REG_CYCLE_INTERVAL: interval_reg = v[31:0];
            REG_START_TIME:     eff_start    = v[TB-1:0];
            REG_STOP_TIME:      stop_reg     = v[TB-1:0];
            REG_LOOP_ENABLE:    loop_reg     = v[0];
            default: ;
        endcase
    endfunction

    // One tick through the model: activation, then the stop check, then the
    // end of cycle, in that order. Returns the result the block must send.
    function automatic sensor_result_t advance_sensor(logic [TB-1:0] t);
        logic           was_active;
        logic           began;
        logic [63:0]    cycle_last;
        sensor_result_t r;
        was_active = sensor_active;
        began      = 1'b0;

        if (!sensor_active && eff_start != TICK_MAX && t >= eff_start) begin
            sensor_active = 1'b1;
            cycle_begin   = t;
            began         = 1'b1;
        end

        // The stop tick counts only while it lies above the effective start.
        if (stop_reg > eff_start && t > stop_reg) begin
            eff_start     = TICK_MAX;
            sensor_active = 1'b0;
        end

        // The end of the cycle saturates at the top of the time axis, so a
        // cycle that would run past it can never be overtaken.
        cycle_last = 64'(cycle_begin) + interval_ticks();
        if (cycle_last > 64'(TICK_MAX)) cycle_last = 64'(TICK_MAX);

        if (sensor_active && 64'(t) > cycle_last) begin
            if (!loop_reg) begin
                eff_start     = TICK_MAX;
                sensor_active = 1'b0;
            end else begin
                // Only one interval is added per tick, even after a long jump.
                cycle_begin = TB'(64'(cycle_begin) + interval_ticks());
                began       = 1'b1;
            end
        end

        r.is_active      = sensor_active;
        r.active_changed = sensor_active != was_active;
        r.cycle_start    = cycle_begin;
        r.cycle_started  = began;
        r.fraction       = sensor_active ? cycle_fraction(t) : '0;
        r.fraction_valid = sensor_active;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders.
    // ------------------------------------------------------------------------
    function automatic void add_write(cts_reg_idx_t idx, logic [63:0] v);
        script_row_t row;
        row.kind   = ROW_WRITE;
        row.reg_id = idx;
        row.value  = v;
        row.typed  = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_tick(logic [TB-1:0] t);
        script_row_t row;
        row.kind   = ROW_TICK;
        row.reg_id = REG_CYCLE_INTERVAL;
        row.value  = 64'(t);
        row.typed  = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endfunction

    // A tick whose result is plain enough to write down by hand.
    function automatic void add_tick_exp(logic [TB-1:0] t, logic act, logic chg,
                                         logic [TB-1:0] cs, logic began,
                                         logic [FB-1:0] frac, logic fvalid);
        script_row_t row;
        row.kind   = ROW_TICK;
        row.reg_id = REG_CYCLE_INTERVAL;
        row.value  = 64'(t);
        row.typed  = 1'b1;
        row.result = '{act, chg, cs, began, frac, fvalid};
        directed_rows.push_back(row);
    endfunction

    // Mostly back to back, often a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] random_tick();
        return {$urandom, $urandom} & 64'(TICK_MAX);
    endfunction

    // ------------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("ERROR result %0d, %s: got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    // Output beat layout from bit 0: is_active, active_changed, cycle_start,
    // cycle_start_changed, fraction; fraction_valid rides on tuser.
    function automatic sensor_result_t unpack_beat();
        sensor_result_t r;
        r.is_active      = m_axis_tdata[0];
        r.active_changed = m_axis_tdata[1];
        r.cycle_start    = m_axis_tdata[TB+1:2];
        r.cycle_started  = m_axis_tdata[TB+2];
        r.fraction       = m_axis_tdata[TB+FB+2:TB+3];
        r.fraction_valid = m_axis_tuser[0];
        return r;
    endfunction

    task automatic check_beat();
        sensor_result_t got;
        sensor_result_t want;
        got = unpack_beat();
        if (pending_results.size() == 0) begin
            flag_mismatch("beat with no result pending", 64'(got.cycle_start), 64'd0);
        end else begin
            want = pending_results.pop_front();
            if (got.is_active !== want.is_active)
                flag_mismatch("is_active", 64'(got.is_active), 64'(want.is_active));
            if (got.active_changed !== want.active_changed)
                flag_mismatch("active_changed", 64'(got.active_changed),
                              64'(want.active_changed));
            if (got.cycle_start !== want.cycle_start)
                flag_mismatch("cycle_start", 64'(got.cycle_start), 64'(want.cycle_start));
            if (got.cycle_started !== want.cycle_started)
                flag_mismatch("cycle_start_changed", 64'(got.cycle_started),
                              64'(want.cycle_started));
            if (got.fraction !== want.fraction)
                flag_mismatch("fraction", 64'(got.fraction), 64'(want.fraction));
            if (got.fraction_valid !== want.fraction_valid)
                flag_mismatch("fraction_valid", 64'(got.fraction_valid),
                              64'(want.fraction_valid));
        end
        results_seen++;
    endtask

    // Result side: every accepted beat is checked, then tready may drop for a
    // random stretch. Runs of 40 results switch between stalling and not.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_beat();
                if (results_seen % 40 == 0) rx_steady = ($urandom_range(0, 2) == 0);
                rx_hold = rx_steady ? 0 : pick_gap();
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_axis_tready <= (rx_hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Driving. A valid that stays high into the next beat is never lowered in
    // the same step, so each valid sees one assignment per step.
    // ------------------------------------------------------------------------
    task automatic send_tick(logic [TB-1:0] t, bit typed, sensor_result_t typed_exp);
        int             gap;
        sensor_result_t predicted;
        gap = tx_steady ? 0 : pick_gap();
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(t);
        do @(posedge aclk); while (!s_axis_tready);
        predicted = advance_sensor(t);
        pending_results.push_back(typed ? typed_exp : predicted);
    endtask

    task automatic write_register(cts_reg_idx_t idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(v);
        do @(posedge aclk); while (!cfg_ready);
        load_register(idx, v);
    endtask

    // Every tick yields exactly one result, so once nothing is pending the
    // block has finished its work and registers may be changed.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        logic [63:0] tick;
        logic [63:0] span;
        logic [63:0] v;
        int          random_ticks;
        bit          first_phase;
        random_ticks = 0;
        first_phase  = 1'b1;

        // From reset: interval 1, start 0, stop off, no looping. A tick at the
        // top of the axis ends the single cycle and leaves the start
        // indefinite, so the next tick cannot wake the sensor.
        add_tick_exp(0, 1, 1, 0, 1, 0, 1);
        add_tick_exp(1, 1, 0, 0, 0, 0, 1);
        add_tick_exp(TICK_MAX, 0, 1, 0, 0, 0, 0);
        add_tick_exp(0, 0, 0, 0, 0, 0, 0);

        // A zero interval counts as one tick; with looping on, one new cycle
        // per beat.
        add_write(REG_CYCLE_INTERVAL, 0);
        add_write(REG_START_TIME, 10);
        add_write(REG_STOP_TIME, 0);
        add_write(REG_LOOP_ENABLE, 1);
        add_tick_exp(9, 0, 0, 0, 0, 0, 0);
        add_tick_exp(10, 1, 1, 10, 1, 0, 1);
        add_tick_exp(12, 1, 0, 11, 1, 0, 1);

        // Start raised above the time while the sensor runs: the fraction
        // must still wrap into the cycle.
        add_write(REG_CYCLE_INTERVAL, 1000);
        add_write(REG_START_TIME, 100);
        add_tick(150);
        add_write(REG_START_TIME, 300);
        add_tick(200);
        add_tick(1012);

        // Explicitly written indefinite start never activates.
        add_write(REG_START_TIME, 64'(TICK_MAX));
        add_write(REG_LOOP_ENABLE, 0);
        add_tick(2012);
        add_tick_exp(TICK_MAX, 0, 0, 1011, 0, 0, 0);

        // Largest interval near the top of the axis: the cycle end saturates.
        add_write(REG_CYCLE_INTERVAL, 32'hFFFF_FFFF);
        add_write(REG_START_TIME, 64'(TICK_MAX - 10));
        add_write(REG_LOOP_ENABLE, 1);
        add_write(REG_STOP_TIME, 64'(TICK_MAX));
        add_tick_exp(TICK_MAX - 10, 1, 1, TICK_MAX - 10, 1, 0, 1);
        add_tick(TICK_MAX);

        // Stop while running, then activation and stop within one tick.
        add_write(REG_START_TIME, 50);
        add_write(REG_STOP_TIME, 60);
        add_write(REG_CYCLE_INTERVAL, 4);
        add_tick_exp(70, 0, 1, TICK_MAX - 10, 0, 0, 0);
        add_write(REG_START_TIME, 50);
        add_tick_exp(70, 0, 0, 70, 1, 0, 0);
        add_write(REG_START_TIME, 50);
        add_tick(55);
        add_tick(58);
        add_tick(60);
        add_tick_exp(61, 0, 1, 59, 0, 0, 0);

        // Interval of 2^16 makes the fraction equal the remainder: all ones.
        add_write(REG_CYCLE_INTERVAL, 65536);
        add_write(REG_START_TIME, 0);
        add_write(REG_STOP_TIME, 0);
        add_write(REG_LOOP_ENABLE, 0);
        add_tick_exp(65535, 1, 1, 65535, 1, 16'hFFFF, 1);
        add_tick(131071);
        add_tick(131072);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_register(directed_rows[i].reg_id, directed_rows[i].value);
            end else begin
                send_tick(TB'(directed_rows[i].value), directed_rows[i].typed,
                          directed_rows[i].result);
            end
        end

        // Random phases: a new register setting, then a run of mostly rising
        // ticks starting just below the start so activation, cycle wraps and
        // stops all come up. Some beats are noise or step backwards.
        while (random_ticks < RANDOM_TICKS) begin
            wait_idle();
            tx_steady = ($urandom_range(0, 3) == 0);

            if (first_phase || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 15))
                    0:       v = 0;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = $urandom;
                    3:       v = 65536;
                    default: v = $urandom_range(1, 40);
                endcase
                write_register(REG_CYCLE_INTERVAL, v);
            end

            // The tick step below is tied to the interval, so cap the span.
            span = (interval_ticks() > 10) ? 64'd20 : 2 * interval_ticks();

            if (first_phase || $urandom_range(0, 7) != 0) begin
                case ($urandom_range(0, 9))
                    0:       v = 64'(TICK_MAX);
                    1:       v = 64'(TICK_MAX) - $urandom_range(0, 300);
                    2:       v = random_tick();
                    default: v = $urandom_range(0, 5000);
                endcase
                write_register(REG_START_TIME, v);
            end

            if (first_phase || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0, 1:    v = 0;
                    2:       v = random_tick();
                    3:       v = 64'(TICK_MAX);
                    default: v = 64'(eff_start) + $urandom_range(0, 10 * span + 5);
                endcase
                if (v > 64'(TICK_MAX)) v = 64'(TICK_MAX);
                write_register(REG_STOP_TIME, v);
            end

            if (first_phase || $urandom_range(0, 1) != 0)
                write_register(REG_LOOP_ENABLE, $urandom_range(0, 1));
            first_phase = 1'b0;

            if (eff_start == TICK_MAX)
                tick = random_tick();
            else if (eff_start > 3)
                tick = 64'(eff_start) - $urandom_range(0, 3);
            else
                tick = 64'(eff_start);

            repeat ($urandom_range(10, 30)) begin
                send_tick(TB'(tick), 1'b0, '0);
                random_ticks++;
                case ($urandom_range(0, 11))
                    0:       tick = random_tick();
                    1:       tick = (tick > 5) ? tick - $urandom_range(1, 5) : 0;
                    2:       tick = tick + interval_ticks() + $urandom_range(0, 2);
                    default: tick = tick + $urandom_range(0, span);
                endcase
                if (tick > 64'(TICK_MAX)) tick = 64'(TICK_MAX);
            end
        end

        // Drain, then wait for any stray beat to show before the verdict.
        wait_idle();
        repeat (80) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run, including long stalls
    // on both sides for every beat.
    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
